[hdl/tpri_pkg.sv]
// Shared types, constants and register-image helpers for the PLL register image block.
// Used by every module under hdl; depends on nothing else.
package tpri_pkg;

	localparam int FRAC_BITS_DEF = 20;
	localparam int CFG_W         = 26;
	localparam int NUM_WRITES    = 12;

	localparam logic [25:0] REF_CLOCK_RST  = 26'd20000000;
	localparam logic [2:0]  REF_DIV_RST    = 3'd0;

	localparam logic [0:0] CFG_REF_CLOCK = 1'b0;
	localparam logic [0:0] CFG_REF_DIV   = 1'b1;

	localparam logic [31:0] VCO_SPLIT_HZ = 32'd1125000000;
	localparam logic [31:0] BW_MIN_HZ    = 32'd3480000;
	localparam logic [31:0] BW_MAX_HZ    = 32'd74470000;
	localparam logic [31:0] BW_OFFSET_HZ = 32'd520000;
	localparam logic [26:0] BW_STEP_HZ   = 27'd290000;

	// step = 16 * 18125: drop four bits, then multiply by ceil(2^37 / 18125)
	localparam logic [22:0] LPF_RECIP = 23'd7582839;
	localparam int          LPF_SHIFT = 37;

	localparam logic [3:0] REG_N_HI   = 4'h0;
	localparam logic [3:0] REG_N_LO   = 4'h1;
	localparam logic [3:0] REG_F_HI   = 4'h2;
	localparam logic [3:0] REG_F_MID  = 4'h3;
	localparam logic [3:0] REG_F_LO   = 4'h4;
	localparam logic [3:0] REG_REFDIV = 4'h5;
	localparam logic [3:0] REG_VCO    = 4'h6;
	localparam logic [3:0] REG_FIXED7 = 4'h7;
	localparam logic [3:0] REG_LPF    = 4'h8;
	localparam logic [3:0] REG_GAIN   = 4'h9;
	localparam logic [3:0] REG_FIXED10 = 4'hA;
	localparam logic [3:0] REG_FIXED11 = 4'hB;

	localparam logic [3:0] ADDR_SEQ [NUM_WRITES] = '{
		REG_N_HI, REG_N_LO, REG_REFDIV, REG_VCO, REG_FIXED7, REG_LPF,
		REG_GAIN, REG_FIXED10, REG_FIXED11, REG_F_HI, REG_F_MID, REG_F_LO
	};
	localparam logic [3:0] LAST_IDX = 4'(NUM_WRITES - 1);

	typedef struct packed {
		logic [31:0]        target_freq_hz;
		logic [31:0]        bandwidth_hz;
		logic signed [7:0]  gain_db;
	} in_word_t;

	typedef struct packed {
		logic [3:0]  reg_addr;
		logic [7:0]  reg_data;
		logic        last;
		logic [31:0] actual_freq_hz;
	} out_word_t;

	typedef struct packed {
		logic [31:0] freq;
		logic [26:0] bw_off;
		logic [3:0]  gain;
	} work_t;

	typedef struct packed {
		logic [14:0] n;
		logic [19:0] frac;
		logic [31:0] actual;
		logic [7:0]  lpf;
		logic [3:0]  gain;
	} res_t;

	function automatic logic [7:0] reg_byte(input logic [3:0] addr, input res_t r,
		input logic [2:0] div_code);
		logic [7:0] b;
		b = 8'h00;
		case (addr)
			REG_N_HI:    b = {1'b1, r.n[14:8]};
			REG_N_LO:    b = r.n[7:0];
			REG_F_HI:    b = {4'h1, r.frac[19:16]};
			REG_F_MID:   b = r.frac[15:8];
			REG_F_LO:    b = r.frac[7:0];
			REG_REFDIV:  b = {div_code, 5'h01};
			REG_VCO:     b = (r.actual >= VCO_SPLIT_HZ) ? 8'h40 : 8'hC0;
			REG_FIXED7:  b = 8'hCC;
			REG_LPF:     b = r.lpf;
			REG_GAIN:    b = {4'h0, r.gain};
			REG_FIXED10: b = 8'h00;
			REG_FIXED11: b = 8'h08;
			default:     b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

[hdl/tpri_front.sv]
// Front end: accepts input words, clamps bandwidth and gain, pushes work into the queue.
// Depends on tpri_pkg.
module tpri_front (
	input  logic             in_valid,
	output logic             in_stall,
	input  tpri_pkg::in_word_t in_word,
	input  logic             full,
	output logic             push,
	output tpri_pkg::work_t  push_word
);
	import tpri_pkg::*;

	logic [31:0] bw_clamped;

	always_comb begin
		if (in_word.bandwidth_hz < BW_MIN_HZ) begin
			bw_clamped = BW_MIN_HZ;
		end else if (in_word.bandwidth_hz > BW_MAX_HZ) begin
			bw_clamped = BW_MAX_HZ;
		end else begin
			bw_clamped = in_word.bandwidth_hz;
		end
		push_word.freq   = in_word.target_freq_hz;
		push_word.bw_off = 27'(bw_clamped - BW_OFFSET_HZ);
		if (in_word.gain_db[7]) begin
			push_word.gain = 4'd0;
		end else if (in_word.gain_db[6:4] != 3'd0) begin
			push_word.gain = 4'd15;
		end else begin
			push_word.gain = in_word.gain_db[3:0];
		end
	end

	assign in_stall = full;
	assign push     = in_valid & ~full;

endmodule

[hdl/tpri_fifo.sv]
// Two-entry work queue between front end and divider.
// Depends on tpri_pkg.
module tpri_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  tpri_pkg::work_t push_word,
	input  logic            pop,
	output tpri_pkg::work_t pop_word,
	output logic            full,
	output logic            not_empty
);
	import tpri_pkg::*;

	work_t      mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_word;
		end
	end

	assign pop_word  = mem_q[rd_ptr_q];
	assign full      = count_q[1];
	assign not_empty = count_q != 2'd0;

endmodule

[hdl/tpri_div.sv]
// Back end divider: four quotient bits per cycle for N and F, filter code by reciprocal multiply.
// Depends on tpri_pkg.
module tpri_div #(
	parameter int FRAC_BITS = tpri_pkg::FRAC_BITS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [25:0]     ref_clock,
	input  logic            work_valid,
	input  tpri_pkg::work_t work_word,
	output logic            pop,
	output logic            res_valid,
	output tpri_pkg::res_t  res_word,
	input  logic            take
);
	import tpri_pkg::*;

	localparam int DW      = ((32 + FRAC_BITS + 3) / 4) * 4;
	localparam int DIV_CYC = DW / 4;
	localparam int CW      = $clog2(DIV_CYC + 1);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [25:0]   rem_q;
	logic [DW-1:0] dq_q;
	logic [31:0]   freq_q;
	logic [3:0]    gain_q;
	logic [22:0]   lx_q;

	logic [25:0]   rem_n;
	logic [DW-1:0] dq_n;
	logic [26:0]   r;
	logic [DW-1:0] d;
	logic [FRAC_BITS+19:0] frac_ext;
	logic [31:0]   ceil_rem;
	logic [45:0]   lpf_prod;

	assign pop = work_valid & ~busy_q & (~done_q | take);

	always_comb begin
		r = {1'b0, rem_q};
		d = dq_q;
		for (int i = 0; i < 4; i++) begin
			r = {r[25:0], d[DW-1]};
			d = {d[DW-2:0], 1'b0};
			if (r >= {1'b0, ref_clock}) begin
				r    = r - {1'b0, ref_clock};
				d[0] = 1'b1;
			end
		end
		rem_n = r[25:0];
		dq_n  = d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			if (take) begin
				done_q <= 1'b0;
			end
			if (pop) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (cnt_q == CW'(DIV_CYC - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			rem_q  <= '0;
			dq_q   <= DW'({work_word.freq, {FRAC_BITS{1'b0}}});
			freq_q <= work_word.freq;
			gain_q <= work_word.gain;
			lx_q   <= work_word.bw_off[26:4];
		end else if (busy_q) begin
			rem_q <= rem_n;
			dq_q  <= dq_n;
		end
	end

	always_comb begin
		frac_ext = {20'b0, dq_q[FRAC_BITS-1:0]};
		ceil_rem = 32'(rem_q >> FRAC_BITS) + 32'(|rem_q[FRAC_BITS-1:0]);
		lpf_prod = {23'd0, lx_q} * {23'd0, LPF_RECIP};
		res_word.lpf  = lpf_prod[LPF_SHIFT+7:LPF_SHIFT];
		res_word.gain = gain_q;
		if (ref_clock == 26'd0) begin
			res_word.n      = '0;
			res_word.frac   = '0;
			res_word.actual = '0;
		end else begin
			res_word.n      = dq_q[FRAC_BITS+14:FRAC_BITS];
			res_word.frac   = frac_ext[19:0];
			res_word.actual = freq_q - ceil_rem;
		end
	end

	assign res_valid = done_q;

endmodule

[hdl/tpri_emit.sv]
// Write sequencer: holds one result and issues its twelve register writes in order.
// Depends on tpri_pkg.
module tpri_emit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [2:0]         ref_div_code,
	input  logic               res_valid,
	input  tpri_pkg::res_t     res_word,
	output logic               take,
	output logic               out_valid,
	input  logic               out_stall,
	output tpri_pkg::out_word_t out_word
);
	import tpri_pkg::*;

	res_t       cur_q;
	logic [3:0] idx_q;
	logic       valid_q;
	logic       fire;
	logic       at_last;

	assign fire    = valid_q & ~out_stall;
	assign at_last = idx_q == LAST_IDX;
	assign take    = res_valid & (~valid_q | (fire & at_last));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else begin
			if (take) begin
				valid_q <= 1'b1;
				idx_q   <= '0;
			end else if (fire) begin
				if (at_last) begin
					valid_q <= 1'b0;
				end else begin
					idx_q <= idx_q + 4'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cur_q <= res_word;
		end
	end

	always_comb begin
		out_word.reg_addr       = ADDR_SEQ[idx_q];
		out_word.reg_data       = reg_byte(ADDR_SEQ[idx_q], cur_q, ref_div_code);
		out_word.last           = at_last;
		out_word.actual_freq_hz = cur_q.actual;
	end

	assign out_valid = valid_q;

endmodule

[hdl/tuner_pll_register_image.sv]
// Fractional-N PLL register image generator, top level.
// An accepted word passes the queue, the divider and the sequencer's result register in order.
// The divider takes DW = 32 + FRAC_BITS rounded up to 4 dividend bits, four per cycle while busy;
// the twelve writes then go out one per cycle unless stalled, while the divider may take the next
// word. Reset clears the queue and sequencer, loads 20 MHz reference, code 0.
module tuner_pll_register_image #(
	parameter int FRAC_BITS = tpri_pkg::FRAC_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  tpri_pkg::in_word_t      in_word,
	output logic                    out_valid,
	input  logic                    out_stall,
	output tpri_pkg::out_word_t     out_word,
	input  logic                    cfg_we,
	input  logic [0:0]              cfg_index,
	input  logic [tpri_pkg::CFG_W-1:0] cfg_data
);
	import tpri_pkg::*;

	logic [25:0] ref_clock_q;
	logic [2:0]  ref_div_q;

	logic  push;
	work_t push_word;
	logic  full;
	logic  pop;
	work_t pop_word;
	logic  not_empty;
	logic  res_valid;
	res_t  res_word;
	logic  take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_clock_q <= REF_CLOCK_RST;
			ref_div_q   <= REF_DIV_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_REF_CLOCK: ref_clock_q <= cfg_data[25:0];
				CFG_REF_DIV:   ref_div_q   <= cfg_data[2:0];
				default:       ref_div_q   <= ref_div_q;
			endcase
		end
	end

	tpri_front u_front (
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_word   (in_word),
		.full      (full),
		.push      (push),
		.push_word (push_word)
	);

	tpri_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_word (push_word),
		.pop       (pop),
		.pop_word  (pop_word),
		.full      (full),
		.not_empty (not_empty)
	);

	tpri_div #(
		.FRAC_BITS (FRAC_BITS)
	) u_div (
		.clk        (clk),
		.arst_n     (arst_n),
		.ref_clock  (ref_clock_q),
		.work_valid (not_empty),
		.work_word  (pop_word),
		.pop        (pop),
		.res_valid  (res_valid),
		.res_word   (res_word),
		.take       (take)
	);

	tpri_emit u_emit (
		.clk          (clk),
		.arst_n       (arst_n),
		.ref_div_code (ref_div_q),
		.res_valid    (res_valid),
		.res_word     (res_word),
		.take         (take),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_word     (out_word)
	);

endmodule
